>>> rtl/bcomp_pkg.sv
// Shared types and constants for the barometric compensation block.
// No dependencies; imported by the divider pipeline and the top level.
`default_nettype none

package bcomp_pkg;

    // Configuration register indexes (byte address = 8 * index)
    typedef enum logic [1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_A    = 2'd1,
        REG_PRESS_B    = 2'd2,
        REG_PRESS_NINE = 2'd3
    } bcomp_reg_t;

    // Quotient bits produced by the long-division pipeline
    localparam int DIV_STAGES = 35;
    // Width of the divisor magnitude and of the partial remainder
    localparam int DIV_W = 36;

    localparam logic signed [20:0] FINE_OFFSET  = 21'sd128000;
    localparam logic signed [50:0] X_BIAS       = 51'sd140737488355328;
    localparam logic signed [36:0] Q_LIMIT      = 37'sd34359738368;
    localparam logic        [11:0] Q_SCALE      = 12'd3125;
    localparam logic signed [39:0] PRESS_MAX    = 40'sd33554431;
    localparam logic signed [23:0] FINE_MAX     = 24'sd524287;
    localparam logic signed [23:0] FINE_MIN     = -24'sd524288;
    localparam logic signed [19:0] TEMP_MAX     = 20'sd32767;
    localparam logic signed [19:0] TEMP_MIN     = -20'sd32768;

    // Per-item fields that ride alongside the division
    typedef struct packed {
        logic signed [15:0] temp;
        logic signed [19:0] tfs;
        logic               fault;
        logic               sat;
        logic               qneg;
    } bcomp_carry_t;

endpackage

`default_nettype wire

>>> rtl/bcomp_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
// No dependencies.
`default_nettype none

interface bcomp_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bcomp_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_centi;
    logic signed [19:0] fine_temperature;
    logic        [24:0] pressure_q8;
    logic               divide_fault;

    modport source (output valid, output temperature_centi, output fine_temperature,
                    output pressure_q8, output divide_fault, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temperature,
                    input pressure_q8, input divide_fault, output ready);
endinterface

`default_nettype wire

>>> rtl/barometric_compensation_top.sv
// Barometric temperature and pressure compensation, fully pipelined.
// Depends on bcomp_pkg, bcomp_if (channel interfaces) and bcomp_div_pipe.
//
//   channel      dir  handshake        payload
//   sample_in    in   valid/ready      raw_temperature[19:0], raw_pressure[19:0]
//   result_out   out  valid/ready      temperature_centi, fine_temperature,
//                                      pressure_q8, divide_fault
//   apb          in   psel/penable     paddr[4:3] selects the register, 64-bit data
//
// One item enters per cycle while the output is not stalled. The pipeline holds
// twelve arithmetic stages, 35 stages of the divider (one quotient bit each),
// three correction stages and the output register.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
// rst_n clears valid bits and calibration registers; payload is not reset.
`default_nettype none

module barometric_compensation_top
    import bcomp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    bcomp_sample_if.sink     sample_in,
    bcomp_result_if.source   result_out
);

    // ---------------- configuration ----------------
    logic [47:0] tcal_reg;
    logic [63:0] pcal_a_reg;
    logic [63:0] pcal_b_reg;
    logic [15:0] pcal_nine_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write the addressed calibration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg      <= '0;
            pcal_a_reg    <= '0;
            pcal_b_reg    <= '0;
            pcal_nine_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (bcomp_reg_t'(paddr[4:3]))
                REG_TEMP_CAL:   tcal_reg      <= pwdata[47:0];
                REG_PRESS_A:    pcal_a_reg    <= pwdata;
                REG_PRESS_B:    pcal_b_reg    <= pwdata;
                REG_PRESS_NINE: pcal_nine_reg <= pwdata[15:0];
                default:        tcal_reg      <= tcal_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (bcomp_reg_t'(paddr[4:3]))
            REG_TEMP_CAL:   prdata = {16'd0, tcal_reg};
            REG_PRESS_A:    prdata = pcal_a_reg;
            REG_PRESS_B:    prdata = pcal_b_reg;
            REG_PRESS_NINE: prdata = {48'd0, pcal_nine_reg};
            default:        prdata = '0;
        endcase
    end

    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = tcal_reg[15:0];
    assign t2 = $signed(tcal_reg[31:16]);
    assign t3 = $signed(tcal_reg[47:32]);
    assign p1 = pcal_a_reg[15:0];
    assign p2 = $signed(pcal_a_reg[31:16]);
    assign p3 = $signed(pcal_a_reg[47:32]);
    assign p4 = $signed(pcal_a_reg[63:48]);
    assign p5 = $signed(pcal_b_reg[15:0]);
    assign p6 = $signed(pcal_b_reg[31:16]);
    assign p7 = $signed(pcal_b_reg[47:32]);
    assign p8 = $signed(pcal_b_reg[63:48]);
    assign p9 = $signed(pcal_nine_reg);

    // ---------------- pipeline control ----------------
    logic        en;
    logic [11:0] pre_vld_reg;
    logic [2:0]  post_vld_reg;
    logic        out_vld_reg;
    logic        div_vld;

    assign en              = !out_vld_reg || result_out.ready;
    assign sample_in.ready = en;

    // ---------------- stage 1: temperature differences ----------------
    logic signed [17:0] s1_tdiff_reg, s1_tdiff_next;
    logic signed [16:0] s1_d_reg, s1_d_next;
    logic        [19:0] adcp_reg [8];

    assign s1_tdiff_next = $signed({1'b0, sample_in.raw_temperature[19:3]})
                         - $signed({1'b0, t1, 1'b0});
    assign s1_d_next     = $signed({1'b0, sample_in.raw_temperature[19:4]})
                         - $signed({1'b0, t1});

    // ---------------- stage 2: first products ----------------
    logic signed [33:0] s2_pa_reg, s2_pa_next;
    logic signed [33:0] s2_dd_reg, s2_dd_next;

    assign s2_pa_next = s1_tdiff_reg * t2;
    assign s2_dd_next = s1_d_reg * s1_d_reg;

    // ---------------- stage 3: scale, second-order product ----------------
    logic signed [22:0] s3_a_reg, s3_a_next;
    logic signed [37:0] s3_bm_reg, s3_bm_next;

    assign s3_a_next  = 23'(s2_pa_reg >>> 11);
    assign s3_bm_next = $signed({1'b0, s2_dd_reg[32:12]}) * t3;

    // ---------------- stage 4: fine temperature ----------------
    logic signed [23:0] s4_tf_reg, s4_tf_next;

    assign s4_tf_next = 24'(s3_a_reg) + 24'(s3_bm_reg >>> 14);

    // ---------------- stage 5: saturate, offset ----------------
    logic signed [15:0] temp_reg [8];
    logic signed [19:0] tfs_reg  [8];
    logic signed [15:0] s5_temp_next;
    logic signed [19:0] s5_tfs_next;
    logic signed [20:0] s5_v_reg, s5_v_next;

    always_comb
    begin
        logic signed [27:0] tf_ext;
        logic signed [27:0] t5;
        logic signed [19:0] tsh;
        tf_ext = 28'(s4_tf_reg);
        t5     = (tf_ext <<< 2) + tf_ext + 28'sd128;
        tsh    = 20'(t5 >>> 8);
        if (tsh > TEMP_MAX)
            s5_temp_next = 16'(TEMP_MAX);
        else if (tsh < TEMP_MIN)
            s5_temp_next = 16'(TEMP_MIN);
        else
            s5_temp_next = tsh[15:0];
        if (s4_tf_reg > FINE_MAX)
            s5_tfs_next = 20'(FINE_MAX);
        else if (s4_tf_reg < FINE_MIN)
            s5_tfs_next = 20'(FINE_MIN);
        else
            s5_tfs_next = s4_tf_reg[19:0];
        s5_v_next = 21'(s5_tfs_next) - FINE_OFFSET;
    end

    // ---------------- stage 6: v products ----------------
    logic signed [39:0] s6_vv_reg, s6_vv_next;
    logic signed [36:0] s6_vp5_reg, s6_vp5_next;
    logic signed [36:0] s6_vp2_reg, s6_vp2_next;

    assign s6_vv_next  = 40'(s5_v_reg) * 40'(s5_v_reg);
    assign s6_vp5_next = s5_v_reg * p5;
    assign s6_vp2_next = s5_v_reg * p2;

    // ---------------- stage 7: v squared products ----------------
    logic signed [55:0] s7_vvp6_reg, s7_vvp6_next;
    logic signed [55:0] s7_vvp3_reg, s7_vvp3_next;
    logic signed [36:0] s7_vp5_reg;
    logic signed [36:0] s7_vp2_reg;

    assign s7_vvp6_next = s6_vv_reg * p6;
    assign s7_vvp3_next = s6_vv_reg * p3;

    // ---------------- stage 8: sums w and x ----------------
    logic signed [59:0] s8_w_reg, s8_w_next;
    logic signed [50:0] s8_x_reg, s8_x_next;

    assign s8_w_next = 60'(s7_vvp6_reg) + (60'(s7_vp5_reg) <<< 17) + (60'(p4) <<< 35);
    assign s8_x_next = 51'(s7_vvp3_reg >>> 8) + (51'(s7_vp2_reg) <<< 12) + X_BIAS;

    // ---------------- stage 9: P1 scaling split, numerator ----------------
    logic signed [50:0] s9_hp1_reg, s9_hp1_next;
    logic        [32:0] s9_lp1_reg, s9_lp1_next;
    logic signed [59:0] s9_n_reg, s9_n_next;
    logic signed [33:0] x_high;
    logic        [20:0] press_span;

    assign x_high      = 34'(s8_x_reg >>> 17);
    assign s9_hp1_next = x_high * $signed({1'b0, p1});
    assign s9_lp1_next = s8_x_reg[16:0] * p1;
    assign press_span  = 21'd1048576 - {1'b0, adcp_reg[7]};
    assign s9_n_next   = $signed({8'd0, press_span, 31'd0}) - s8_w_reg;

    // ---------------- stage 10: divisor, numerator magnitude ----------------
    logic signed [35:0] s10_div_reg, s10_div_next;
    logic        [58:0] s10_nabs_reg, s10_nabs_next;
    logic               s10_nneg_reg;
    logic               s10_fault_reg, s10_fault_next;
    logic signed [51:0] div_sum;

    assign div_sum        = 52'(s9_hp1_reg) + $signed({36'd0, s9_lp1_reg[32:17]});
    assign s10_div_next   = 36'(div_sum >>> 16);
    assign s10_fault_next = (s10_div_next == '0);
    assign s10_nabs_next  = s9_n_reg[59] ? 59'(-s9_n_reg) : 59'(s9_n_reg);

    // ---------------- stage 11: divisor magnitude, scaled numerator ----------------
    logic [DIV_W-1:0] s11_dabs_reg, s11_dabs_next;
    logic [70:0]      s11_nm_reg, s11_nm_next;
    logic             s11_qneg_reg;
    logic             s11_fault_reg;

    assign s11_dabs_next = s10_div_reg[35] ? DIV_W'(-s10_div_reg) : DIV_W'(s10_div_reg);
    assign s11_nm_next   = 71'(s10_nabs_reg) * 71'(Q_SCALE);

    // ---------------- stage 12: range check, divider setup ----------------
    logic [DIV_W-1:0]      s12_dabs_reg;
    logic [DIV_W-1:0]      s12_rem_reg;
    logic [DIV_STAGES-1:0] s12_low_reg;
    logic                  s12_sat_reg;
    logic                  s12_qneg_reg;
    logic                  s12_fault_reg;
    bcomp_carry_t          s12_carry;

    assign s12_carry = '{temp: temp_reg[7], tfs: tfs_reg[7], fault: s12_fault_reg,
                         sat: s12_sat_reg, qneg: s12_qneg_reg};

    // Register stages 1 to 12: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
        end
        else if (en)
        begin
            pre_vld_reg <= {pre_vld_reg[10:0], sample_in.valid};
        end
    end

    // Register stages 1 to 12: payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tdiff_reg  <= s1_tdiff_next;
            s1_d_reg      <= s1_d_next;
            adcp_reg[0]   <= sample_in.raw_pressure;
            for (int k = 1; k < 8; k++)
            begin
                adcp_reg[k] <= adcp_reg[k-1];
                temp_reg[k] <= temp_reg[k-1];
                tfs_reg[k]  <= tfs_reg[k-1];
            end
            s2_pa_reg     <= s2_pa_next;
            s2_dd_reg     <= s2_dd_next;
            s3_a_reg      <= s3_a_next;
            s3_bm_reg     <= s3_bm_next;
            s4_tf_reg     <= s4_tf_next;
            temp_reg[0]   <= s5_temp_next;
            tfs_reg[0]    <= s5_tfs_next;
            s5_v_reg      <= s5_v_next;
            s6_vv_reg     <= s6_vv_next;
            s6_vp5_reg    <= s6_vp5_next;
            s6_vp2_reg    <= s6_vp2_next;
            s7_vvp6_reg   <= s7_vvp6_next;
            s7_vvp3_reg   <= s7_vvp3_next;
            s7_vp5_reg    <= s6_vp5_reg;
            s7_vp2_reg    <= s6_vp2_reg;
            s8_w_reg      <= s8_w_next;
            s8_x_reg      <= s8_x_next;
            s9_hp1_reg    <= s9_hp1_next;
            s9_lp1_reg    <= s9_lp1_next;
            s9_n_reg      <= s9_n_next;
            s10_div_reg   <= s10_div_next;
            s10_nabs_reg  <= s10_nabs_next;
            s10_nneg_reg  <= s9_n_reg[59];
            s10_fault_reg <= s10_fault_next;
            s11_dabs_reg  <= s11_dabs_next;
            s11_nm_reg    <= s11_nm_next;
            s11_qneg_reg  <= s10_nneg_reg ^ s10_div_reg[35];
            s11_fault_reg <= s10_fault_reg;
            s12_dabs_reg  <= s11_dabs_reg;
            s12_rem_reg   <= s11_nm_reg[70:35];
            s12_low_reg   <= s11_nm_reg[34:0];
            s12_sat_reg   <= s11_nm_reg >= {s11_dabs_reg, 35'd0};
            s12_qneg_reg  <= s11_qneg_reg;
            s12_fault_reg <= s11_fault_reg;
        end
    end

    // ---------------- long division ----------------
    bcomp_carry_t          div_carry;
    logic [DIV_STAGES-1:0] div_quo;

    bcomp_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_vld_reg[11]),
        .in_carry  (s12_carry),
        .in_dabs   (s12_dabs_reg),
        .in_rem    (s12_rem_reg),
        .in_low    (s12_low_reg),
        .out_valid (div_vld),
        .out_carry (div_carry),
        .out_quo   (div_quo)
    );

    // ---------------- stage M: signed, clamped quotient ----------------
    logic signed [36:0] sm_q_next;
    logic signed [36:0] q_reg [3];
    bcomp_carry_t       post_carry_reg [3];

    always_comb
    begin
        logic signed [36:0] qmag;
        qmag      = div_carry.sat ? Q_LIMIT : $signed({2'b00, div_quo});
        sm_q_next = div_carry.qneg ? -qmag : qmag;
    end

    // ---------------- stage N: second-order products ----------------
    logic signed [23:0] q13;
    logic signed [45:0] sn_q13sq_reg, sn_q13sq_next;
    logic signed [52:0] sn_p8q_reg, sn_p8q_next;

    assign q13           = 24'(q_reg[0] >>> 13);
    assign sn_q13sq_next = q13 * q13;
    assign sn_p8q_next   = q_reg[0] * p8;

    // ---------------- stage O: correction terms ----------------
    logic signed [36:0] so_c9_reg, so_c9_next;
    logic signed [33:0] so_c8_reg, so_c8_next;

    assign so_c9_next = 37'((62'(p9) * 62'(sn_q13sq_reg)) >>> 25);
    assign so_c8_next = 34'(sn_p8q_reg >>> 19);

    // ---------------- stage P: final pressure ----------------
    logic signed [15:0] out_temp_reg;
    logic signed [19:0] out_tfs_reg;
    logic        [24:0] out_press_reg, out_press_next;
    logic               out_fault_reg;

    always_comb
    begin
        logic signed [39:0] qsum;
        logic signed [39:0] pval;
        qsum = 40'(q_reg[2]) + 40'(so_c9_reg) + 40'(so_c8_reg);
        pval = (qsum >>> 8) + (40'(p7) <<< 4);
        if (post_carry_reg[2].fault || pval < 40'sd0)
            out_press_next = '0;
        else if (pval > PRESS_MAX)
            out_press_next = 25'(PRESS_MAX);
        else
            out_press_next = pval[24:0];
    end

    // Advance post-division valid bits and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            post_vld_reg <= {post_vld_reg[1:0], div_vld};
            out_vld_reg  <= post_vld_reg[2];
        end
    end

    // Advance post-division payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]          <= sm_q_next;
            post_carry_reg[0] <= div_carry;
            for (int k = 1; k < 3; k++)
            begin
                q_reg[k]          <= q_reg[k-1];
                post_carry_reg[k] <= post_carry_reg[k-1];
            end
            sn_q13sq_reg  <= sn_q13sq_next;
            sn_p8q_reg    <= sn_p8q_next;
            so_c9_reg     <= so_c9_next;
            so_c8_reg     <= so_c8_next;
            out_temp_reg  <= post_carry_reg[2].temp;
            out_tfs_reg   <= post_carry_reg[2].tfs;
            out_press_reg <= out_press_next;
            out_fault_reg <= post_carry_reg[2].fault;
        end
    end

    assign result_out.valid             = out_vld_reg;
    assign result_out.temperature_centi = out_temp_reg;
    assign result_out.fine_temperature  = out_tfs_reg;
    assign result_out.pressure_q8       = out_press_reg;
    assign result_out.divide_fault      = out_fault_reg;

    // ---------------- assertions ----------------
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.divide_fault |-> result_out.pressure_q8 == '0)
        else $error("divide fault with non-zero pressure");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pre_vld_reg) && $stable(post_vld_reg))
        else $error("pipeline moved during a stall");

    a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pre_vld_reg[11] && s12_fault_reg |-> s12_sat_reg)
        else $error("zero divisor not flagged as saturated");

endmodule

`default_nettype wire

>>> rtl/bcomp_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, stalls as a whole.
// Depends on bcomp_pkg.
`default_nettype none

module bcomp_div_pipe
    import bcomp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire bcomp_carry_t          in_carry,
    input  wire logic [DIV_W-1:0]      in_dabs,
    input  wire logic [DIV_W-1:0]      in_rem,
    input  wire logic [DIV_STAGES-1:0] in_low,
    output logic                       out_valid,
    output bcomp_carry_t               out_carry,
    output logic [DIV_STAGES-1:0]      out_quo
);

    logic [DIV_STAGES-1:0] vld_reg;
    bcomp_carry_t          carry_reg [DIV_STAGES];
    logic [DIV_W-1:0]      dabs_reg  [DIV_STAGES];
    logic [DIV_W-1:0]      rem_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] low_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_reg   [DIV_STAGES];

    logic [DIV_W-1:0]      rem_next  [DIV_STAGES];
    logic [DIV_STAGES-1:0] low_next  [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_next  [DIV_STAGES];

    // Shift in one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        logic [DIV_W-1:0]      rem_in;
        logic [DIV_STAGES-1:0] low_in;
        logic [DIV_STAGES-1:0] quo_in;
        logic [DIV_W-1:0]      dabs_in;
        logic [DIV_W:0]        trial;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in  = in_rem;
                low_in  = in_low;
                quo_in  = '0;
                dabs_in = in_dabs;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                low_in  = low_reg[k-1];
                quo_in  = quo_reg[k-1];
                dabs_in = dabs_reg[k-1];
            end
            trial = {rem_in, low_in[DIV_STAGES-1]};
            low_next[k] = {low_in[DIV_STAGES-2:0], 1'b0};
            if (trial >= {1'b0, dabs_in})
            begin
                rem_next[k] = DIV_W'(trial - {1'b0, dabs_in});
                quo_next[k] = {quo_in[DIV_STAGES-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = DIV_W'(trial);
                quo_next[k] = {quo_in[DIV_STAGES-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                if (k == 0)
                begin
                    carry_reg[k] <= in_carry;
                    dabs_reg[k]  <= in_dabs;
                end
                else
                begin
                    carry_reg[k] <= carry_reg[k-1];
                    dabs_reg[k]  <= dabs_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_carry = carry_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for barometric_compensation_top: calibration over APB,
// raw samples in and compensated readings out. Needs bcomp_pkg and bcomp_if.
// Readings are predicted at sample acceptance and checked in order at the output.
`default_nettype none

module tb_top;
    import bcomp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int FLUSH_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        logic [19:0] t;
        logic [19:0] p;
    } sample_t;

    typedef struct {
        logic [15:0] centi;
        logic [19:0] fine;
        logic [24:0] press;
        logic        fault;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    bcomp_sample_if sample_ch ();
    bcomp_result_if result_ch ();

    barometric_compensation_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_ch.sink),
        .result_out (result_ch.source)
    );

    // Calibration copy used by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_nine;

    sample_t  sample_q[$];
    reading_t reading_q[$];

    int  errors;
    int  idle_cycles;
    int  hold_req;
    int  hold_done;
    int  hold_left;
    bit  calm;
    bit  send_pause;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint word16(logic [63:0] w, int pos);
        logic [15:0] f;
        f = w[pos +: 16];
        return longint'($signed(f));
    endfunction

    // Integer compensation of one raw temperature/pressure pair
    function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, b, d, tf, tfs, centi, press, v, w, x, h, l, dv;
        longint n, qa, ra, q, q13, c9, c8, lim;
        reading_t r;
        adc_t = longint'(raw_t);
        adc_p = longint'(raw_p);
        t1 = longint'(cal_temp[15:0]);
        t2 = word16({16'd0, cal_temp}, 16);
        t3 = word16({16'd0, cal_temp}, 32);
        p1 = longint'(cal_press_a[15:0]);
        p2 = word16(cal_press_a, 16);
        p3 = word16(cal_press_a, 32);
        p4 = word16(cal_press_a, 48);
        p5 = word16(cal_press_b, 0);
        p6 = word16(cal_press_b, 16);
        p7 = word16(cal_press_b, 32);
        p8 = word16(cal_press_b, 48);
        p9 = word16({48'd0, cal_press_nine}, 0);
        lim = longint'(1) <<< 35;
        press = 0;
        r.fault = 1'b0;

        // temperature
        a = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
        d = (adc_t >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        centi = sat((tf * 5 + 128) >>> 8, -32768, 32767);
        tfs = sat(tf, -524288, 524287);

        // pressure, using the saturated fine term
        v = tfs - 128000;
        w = v * v * p6 + v * p5 * 131072 + p4 * lim;
        x = ((v * v * p3) >>> 8) + v * p2 * 4096 + (longint'(1) <<< 47);
        h = x >>> 17;
        l = x - h * 131072;
        dv = (h * p1 + ((l * p1) >>> 17)) >>> 16;
        if (dv == 0)
        begin
            r.fault = 1'b1;
        end
        else
        begin
            n = (longint'(1048576) - adc_p) * (longint'(1) <<< 31) - w;
            qa = n / dv;
            ra = n % dv;
            if (qa > lim / 3125)
                q = lim;
            else if (qa < -(lim / 3125))
                q = -lim;
            else
                q = sat(qa * 3125 + (ra * 3125) / dv, -lim, lim);
            q13 = q >>> 13;
            c9 = (p9 * q13 * q13) >>> 25;
            c8 = (p8 * q) >>> 19;
            press = sat(((q + c9 + c8) >>> 8) + p7 * 16, 0, 33554431);
        end
        r.centi = centi[15:0];
        r.fine  = tfs[19:0];
        r.press = press[24:0];
        return r;
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Sample driver: predict on acceptance, then offer the next item
    always @(posedge clk or negedge rst_n)
    begin : sample_drive
        logic    busy;
        sample_t nx;
        if (!rst_n)
        begin
            sample_ch.valid           <= 1'b0;
            sample_ch.raw_temperature <= '0;
            sample_ch.raw_pressure    <= '0;
        end
        else
        begin
            busy = sample_ch.valid;
            if (sample_ch.valid && sample_ch.ready)
            begin
                reading_q.push_back(compensate(sample_ch.raw_temperature,
                                               sample_ch.raw_pressure));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (sample_q.size() > 0 && !send_pause &&
                    (calm || $urandom_range(99) >= 20))
                begin
                    nx = sample_q.pop_front();
                    sample_ch.valid           <= 1'b1;
                    sample_ch.raw_temperature <= nx.t;
                    sample_ch.raw_pressure    <= nx.p;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, drive ready
    always @(posedge clk or negedge rst_n)
    begin : result_watch
        reading_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (reading_q.size() == 0)
                begin
                    note_error("reading with no sample pending");
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (result_ch.temperature_centi !== want.centi ||
                        result_ch.fine_temperature !== want.fine ||
                        result_ch.pressure_q8 !== want.press ||
                        result_ch.divide_fault !== want.fault)
                        note_error($sformatf(
                            "exp t=%0d f=%0d p=%0d df=%0b got t=%0d f=%0d p=%0d df=%0b",
                            $signed(want.centi), $signed(want.fine), want.press,
                            want.fault, result_ch.temperature_centi,
                            result_ch.fine_temperature, result_ch.pressure_q8,
                            result_ch.divide_fault));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_req != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= calm || $urandom_range(99) >= 20;
            end
        end
    end

    // Watchdog: count cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input bcomp_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_CAL:   cal_temp       = val[47:0];
            REG_PRESS_A:    cal_press_a    = val;
            REG_PRESS_B:    cal_press_b    = val;
            REG_PRESS_NINE: cal_press_nine = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [63:0] a,
                            input logic [63:0] b, input logic [15:0] nine);
        reg_write(REG_TEMP_CAL, {16'd0, t});
        reg_write(REG_PRESS_A, a);
        reg_write(REG_PRESS_B, b);
        reg_write(REG_PRESS_NINE, {48'd0, nine});
    endtask

    task automatic add_sample(input logic [19:0] t, input logic [19:0] p);
        sample_t s;
        s.t = t;
        s.p = p;
        sample_q.push_back(s);
    endtask

    // Plausible sensor readings for half the items, full-range noise and extremes for the rest
    task automatic add_random(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(9);
            if (k < 5)
                add_sample(20'($urandom_range(600000, 350000)),
                           20'($urandom_range(500000, 150000)));
            else if (k < 9)
                add_sample(20'($urandom), 20'($urandom));
            else
                add_sample($urandom_range(1) ? 20'hFFFFF : 20'h0,
                           $urandom_range(1) ? 20'hFFFFF : 20'h0);
        end
    endtask

    // Wait until every item is through and the pipeline is empty
    task automatic drain();
        while (sample_q.size() > 0 || sample_ch.valid || reading_q.size() > 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] jitter(logic [63:0] w);
        logic [63:0] r;
        for (int i = 0; i < 4; i++)
            r[i*16 +: 16] = w[i*16 +: 16] + 16'($urandom_range(64)) - 16'd32;
        return r;
    endfunction

    initial
    begin : stimulus
        logic [47:0] real_t;
        logic [63:0] real_a;
        logic [63:0] real_b;
        logic [63:0] rt;
        errors         = 0;
        idle_cycles    = 0;
        hold_req       = 0;
        hold_done      = 0;
        hold_left      = 0;
        calm           = 1'b0;
        send_pause     = 1'b0;
        cal_temp       = '0;
        cal_press_a    = '0;
        cal_press_b    = '0;
        cal_press_nine = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.raw_temperature = '0;
        sample_ch.raw_pressure    = '0;
        result_ch.ready           = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: divisor is zero, every reading faults
        add_sample(20'h00000, 20'h00000);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'h00000, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'h00000);
        add_sample(20'hAAAAA, 20'h55555);
        add_sample(20'h55555, 20'hAAAAA);
        drain();

        // Typical factory calibration
        real_t = {16'hFC18, 16'd26435, 16'd27504};
        real_a = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
        real_b = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        load_cal(real_t, real_a, real_b, 16'd6000);
        add_sample(20'd519888, 20'd415148);
        add_sample(20'h00000, 20'h00000);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'h00000, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'h00000);
        add_sample(20'hAAAAA, 20'h55555);
        add_sample(20'h55555, 20'hAAAAA);
        add_sample(20'd440064, 20'd300000);
        add_sample(20'd600000, 20'd100000);
        add_sample(20'd350000, 20'd900000);
        add_random(300);

        // Long output stall while samples keep coming, then a full pause
        while (sample_q.size() > 200)
            @(posedge clk);
        hold_req <= hold_req + 1;
        while (sample_q.size() > 80)
            @(posedge clk);
        send_pause <= 1'b1;
        @(posedge clk);
        while (sample_ch.valid || reading_q.size() > 0)
            @(posedge clk);
        send_pause <= 1'b0;
        drain();

        // All ones, with no idling on either side
        calm = 1'b1;
        load_cal('1, '1, '1, '1);
        add_random(200);
        drain();
        calm = 1'b0;

        // Largest positive words
        load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {4{16'h7FFF}}, 16'h7FFF);
        add_random(200);
        drain();

        // Most negative words and the smallest non-zero P1
        load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                 {4{16'h8000}}, 16'h8000);
        add_random(200);
        drain();

        // Fully random calibration
        for (int i = 0; i < 4; i++)
        begin
            rt = {$urandom, $urandom};
            load_cal(rt[47:0], {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
            add_random(150);
            drain();
        end

        // Plausible calibration with small offsets
        for (int i = 0; i < 3; i++)
        begin
            rt = jitter({16'd0, real_t});
            load_cal(rt[47:0], jitter(real_a), jitter(real_b),
                     16'd6000 + 16'($urandom_range(2000)) - 16'd1000);
            add_random(150);
            drain();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
